// File: hdl/sprite_sheet_glyph_box_finder_assert.svh
// Assertion macros for the glyph box finder.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef SPRITE_SHEET_GLYPH_BOX_FINDER_ASSERT_SVH
`define SPRITE_SHEET_GLYPH_BOX_FINDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GBF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GBF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/gbf_pkg.sv
// Shared types, codes and microprogram of the glyph box finder.
// No dependencies; used by gbf_seq, gbf_dp and the top level.
package gbf_pkg;

  localparam int CFG_W = 9;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_FIND    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic REG_SHEET_WIDTH  = 1'b0;
  localparam logic REG_SHEET_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SHEET_DIM_RESET = 9'd256;

  // Opaque red with red in the low byte and alpha in the high byte.
  localparam logic [31:0] RED_MARKER = 32'hFF0000FF;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [31:0] pixel_color;
  } item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] box_x;
    logic [7:0] box_y;
    logic [8:0] box_w;
    logic [8:0] box_h;
    logic       usable;
  } result_t;

  typedef enum logic [1:0] {
    A_ORIGIN,
    A_CURSOR,
    A_ROW,
    A_COL
  } asel_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_KEY,
    OP_WRAP,
    OP_XINC,
    OP_FIRST,
    OP_WINC,
    OP_HINC,
    OP_EMIT,
    OP_END
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_DONE,
    C_YEND,
    C_NEWPIX,
    C_KEYPIX,
    C_ROWEND,
    C_COLEND
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t S_START = 4'd0;
  localparam step_t S_KEY   = 4'd1;
  localparam step_t S_WRAP  = 4'd2;
  localparam step_t S_CHKY  = 4'd3;
  localparam step_t S_TEST  = 4'd4;
  localparam step_t S_FIRST = 4'd5;
  localparam step_t S_WLOOP = 4'd6;
  localparam step_t S_WTEST = 4'd7;
  localparam step_t S_HLOOP = 4'd8;
  localparam step_t S_HTEST = 4'd9;
  localparam step_t S_EMIT  = 4'd10;
  localparam step_t S_END   = 4'd11;

  // One control word. The operation runs every time, or only when the
  // branch falls through if op_fall is set.
  typedef struct packed {
    cond_t cond;
    step_t jt;
    step_t jf;
    op_t   op;
    logic  op_fall;
    asel_t asel;
    logic  fin;
  } uword_t;

  typedef struct packed {
    op_t   op;
    asel_t asel;
  } ctrl_t;

  typedef struct packed {
    logic scan_done;
    logic y_end;
    logic new_pix;
    logic row_end;
    logic col_end;
  } stat_t;

  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    case (pc)
      S_START: w = '{cond: C_DONE, jt: S_END, jf: S_KEY, op: OP_NOP,
                     op_fall: 1'b0, asel: A_ORIGIN, fin: 1'b0};
      S_KEY:   w = '{cond: C_NONE, jt: S_WRAP, jf: S_WRAP, op: OP_KEY,
                     op_fall: 1'b0, asel: A_ORIGIN, fin: 1'b0};
      S_WRAP:  w = '{cond: C_NONE, jt: S_CHKY, jf: S_CHKY, op: OP_WRAP,
                     op_fall: 1'b0, asel: A_ORIGIN, fin: 1'b0};
      S_CHKY:  w = '{cond: C_YEND, jt: S_END, jf: S_TEST, op: OP_NOP,
                     op_fall: 1'b0, asel: A_CURSOR, fin: 1'b0};
      S_TEST:  w = '{cond: C_NEWPIX, jt: S_FIRST, jf: S_WRAP, op: OP_XINC,
                     op_fall: 1'b1, asel: A_CURSOR, fin: 1'b0};
      S_FIRST: w = '{cond: C_NONE, jt: S_WLOOP, jf: S_WLOOP, op: OP_FIRST,
                     op_fall: 1'b0, asel: A_CURSOR, fin: 1'b0};
      S_WLOOP: w = '{cond: C_ROWEND, jt: S_HLOOP, jf: S_WTEST, op: OP_NOP,
                     op_fall: 1'b0, asel: A_ROW, fin: 1'b0};
      S_WTEST: w = '{cond: C_KEYPIX, jt: S_HLOOP, jf: S_WLOOP, op: OP_WINC,
                     op_fall: 1'b1, asel: A_ROW, fin: 1'b0};
      S_HLOOP: w = '{cond: C_COLEND, jt: S_EMIT, jf: S_HTEST, op: OP_NOP,
                     op_fall: 1'b0, asel: A_COL, fin: 1'b0};
      S_HTEST: w = '{cond: C_KEYPIX, jt: S_EMIT, jf: S_HLOOP, op: OP_HINC,
                     op_fall: 1'b1, asel: A_COL, fin: 1'b0};
      S_EMIT:  w = '{cond: C_NONE, jt: S_START, jf: S_START, op: OP_EMIT,
                     op_fall: 1'b0, asel: A_ORIGIN, fin: 1'b1};
      S_END:   w = '{cond: C_NONE, jt: S_START, jf: S_START, op: OP_END,
                     op_fall: 1'b0, asel: A_ORIGIN, fin: 1'b1};
      default: w = '{cond: C_NONE, jt: S_START, jf: S_START, op: OP_NOP,
                     op_fall: 1'b0, asel: A_ORIGIN, fin: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/gbf_seq.sv
// Microprogram sequencer: step counter, branch test and control word issue.
// Depends on gbf_pkg for the control word, status and the program table.
module gbf_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  gbf_pkg::stat_t  stat,
  output gbf_pkg::ctrl_t  ctrl,
  output logic            busy
);

  gbf_pkg::step_t  pc;
  gbf_pkg::uword_t word;
  logic            taken;

  assign word = gbf_pkg::ucode(pc);

  always_comb begin
    case (word.cond)
      gbf_pkg::C_NONE:   taken = 1'b0;
      gbf_pkg::C_DONE:   taken = stat.scan_done;
      gbf_pkg::C_YEND:   taken = stat.y_end;
      gbf_pkg::C_NEWPIX: taken = stat.new_pix;
      gbf_pkg::C_KEYPIX: taken = !stat.new_pix;
      gbf_pkg::C_ROWEND: taken = stat.row_end;
      gbf_pkg::C_COLEND: taken = stat.col_end;
      default:           taken = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.asel = word.asel;
    if (!busy || (word.op_fall && taken)) begin
      ctrl.op = gbf_pkg::OP_NOP;
    end else begin
      ctrl.op = word.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= gbf_pkg::S_START;
    end else if (!busy) begin
      if (go) begin
        busy <= 1'b1;
        pc   <= gbf_pkg::S_START;
      end
    end else begin
      pc <= taken ? word.jt : word.jf;
      if (word.fin) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/gbf_dp.sv
// Datapath: sheet store, scan cursor, box counters and result register.
// Depends on gbf_pkg; driven by the control words of gbf_seq.
module gbf_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CW = $clog2(MAX_WIDTH + 1),
  parameter int RW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  gbf_pkg::ctrl_t    ctrl,
  output gbf_pkg::stat_t    stat,
  input  logic [CW-1:0]     w,
  input  logic [RW-1:0]     h,
  input  logic              wr_en,
  input  logic [7:0]        wr_x,
  input  logic [7:0]        wr_y,
  input  logic [31:0]       wr_color,
  input  logic              restart,
  output logic              done,
  output gbf_pkg::result_t  result
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = 2 ** (XW + YW);

  logic [31:0]   mem [0:DEPTH-1];
  logic [31:0]   rdata;
  logic [31:0]   key;
  logic [31:0]   first;
  logic [CW-1:0] cx;
  logic [RW-1:0] cy;
  logic [RW-1:0] row_height;
  logic [CW-1:0] bw;
  logic [RW-1:0] bh;
  logic          scan_done;
  logic [CW:0]   xsum;
  logic [RW:0]   ysum;
  logic [XW-1:0] rx;
  logic [YW-1:0] ry;
  logic          wr_ok;

  assign xsum = {1'b0, cx} + {1'b0, bw};
  assign ysum = {1'b0, cy} + {1'b0, bh};

  always_comb begin
    case (ctrl.asel)
      gbf_pkg::A_CURSOR: begin
        rx = XW'(cx);
        ry = YW'(cy);
      end
      gbf_pkg::A_ROW: begin
        rx = XW'(xsum);
        ry = YW'(cy);
      end
      gbf_pkg::A_COL: begin
        rx = XW'(cx);
        ry = YW'(ysum);
      end
      default: begin
        rx = '0;
        ry = '0;
      end
    endcase
  end

  assign wr_ok = wr_en && (32'(wr_x) < MAX_WIDTH) && (32'(wr_y) < MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[{YW'(wr_y), XW'(wr_x)}] <= wr_color;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[{ry, rx}];
  end

  assign stat.scan_done = scan_done;
  assign stat.y_end     = (cy >= h);
  assign stat.new_pix   = (rdata != key);
  assign stat.row_end   = (xsum >= {1'b0, w});
  assign stat.col_end   = (ysum >= {1'b0, h});

  always_ff @(posedge clk) begin
    if (rst) begin
      cx         <= '0;
      cy         <= '0;
      row_height <= RW'(1);
      scan_done  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (restart) begin
        cx         <= '0;
        cy         <= '0;
        row_height <= RW'(1);
        scan_done  <= 1'b0;
      end else begin
        case (ctrl.op)
          gbf_pkg::OP_WRAP: begin
            if (cx >= w) begin
              cx         <= '0;
              cy         <= cy + row_height;
              row_height <= RW'(1);
            end
          end
          gbf_pkg::OP_XINC: cx <= cx + CW'(1);
          gbf_pkg::OP_EMIT: begin
            cx         <= CW'(xsum);
            row_height <= bh;
            done       <= 1'b1;
          end
          gbf_pkg::OP_END: begin
            scan_done <= 1'b1;
            done      <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      gbf_pkg::OP_KEY: key <= rdata;
      gbf_pkg::OP_FIRST: begin
        first <= rdata;
        bw    <= '0;
        bh    <= '0;
      end
      gbf_pkg::OP_WINC: bw <= bw + CW'(1);
      gbf_pkg::OP_HINC: bh <= bh + RW'(1);
      gbf_pkg::OP_EMIT: begin
        result.found <= 1'b1;
        if (first != gbf_pkg::RED_MARKER) begin
          result.box_x  <= 8'(cx);
          result.box_y  <= 8'(cy);
          result.box_w  <= 9'(bw);
          result.box_h  <= 9'(bh);
          result.usable <= 1'b1;
        end else begin
          result.box_x  <= '0;
          result.box_y  <= '0;
          result.box_w  <= '0;
          result.box_h  <= '0;
          result.usable <= 1'b0;
        end
      end
      gbf_pkg::OP_END: result <= '0;
      default: ;
    endcase
  end

endmodule

// File: hdl/sprite_sheet_glyph_box_finder.sv
// Top level of the glyph box finder: command port, sheet size registers.
// Depends on gbf_pkg, gbf_seq, gbf_dp and the assertion macro header.
//
// A command word is taken at a clock edge where start is high and busy is
// low. A pixel write or a scan restart takes effect at that edge and busy
// stays low. A find raises busy and runs a short microprogram over the sheet
// store; the store has a single read port and each pixel is read in one step
// and compared in the next. Busy stays high until the find has measured a
// box, has run off the bottom of the sheet or has met a sheet whose end was
// already reported. The result word appears on result with done high for
// exactly one cycle, in the same cycle that busy falls; the receiver cannot
// hold it off, so it must take the word in that cycle. The sheet store is
// not cleared at reset: reading a pixel that was never written gives an
// undefined value, so the whole sheet in use, including the key pixel at the
// origin, should be written before the first find. The user must write the
// sheet size registers through cfg_we, cfg_index and cfg_data only while the
// block is idle; the block itself does not enforce this. A size of zero
// counts as one and a size above the maximum counts as the maximum.
`include "sprite_sheet_glyph_box_finder_assert.svh"

module sprite_sheet_glyph_box_finder #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  gbf_pkg::item_t           item,
  output logic                     busy,
  output logic                     done,
  output gbf_pkg::result_t         result,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [gbf_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [gbf_pkg::CFG_W-1:0] sheet_width;
  logic [gbf_pkg::CFG_W-1:0] sheet_height;
  logic [CW-1:0]             w;
  logic [RW-1:0]             h;
  logic                      accept;
  logic                      find_go;
  gbf_pkg::ctrl_t            ctrl;
  gbf_pkg::stat_t            stat;

  assign accept  = start && !busy;
  assign find_go = accept && (item.command == gbf_pkg::CMD_FIND);

  // Sheet size registers, raw as written.
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_width  <= gbf_pkg::SHEET_DIM_RESET;
      sheet_height <= gbf_pkg::SHEET_DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gbf_pkg::REG_SHEET_WIDTH:  sheet_width  <= cfg_data;
        gbf_pkg::REG_SHEET_HEIGHT: sheet_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sheet size, held between one and the store's maximum.
  always_comb begin
    if (sheet_width == '0) begin
      w = CW'(1);
    end else if (32'(sheet_width) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(sheet_width);
    end
    if (sheet_height == '0) begin
      h = RW'(1);
    end else if (32'(sheet_height) > MAX_HEIGHT) begin
      h = RW'(MAX_HEIGHT);
    end else begin
      h = RW'(sheet_height);
    end
  end

  gbf_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .go   (find_go),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  gbf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .w        (w),
    .h        (h),
    .wr_en    (accept && (item.command == gbf_pkg::CMD_WRITE)),
    .wr_x     (item.pixel_x),
    .wr_y     (item.pixel_y),
    .wr_color (item.pixel_color),
    .restart  (accept && (item.command == gbf_pkg::CMD_RESTART)),
    .done     (done),
    .result   (result)
  );

  // A result only ever appears once the microprogram has handed back control.
  `GBF_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  // An accepted find always starts the microprogram.
  `GBF_ASSERT_NXT(a_find_busy, clk, rst, find_go, busy, "find not started")
  // The end-of-sheet word carries no box.
  `GBF_ASSERT_IMP(a_nf_empty, clk, rst, done && !result.found, result == '0, "end word not empty")

endmodule

// File: tb/gbf_box_checker.sv
`timescale 1ns / 100ps
// Checker for the glyph box finder: keeps its own copy of the sheet and scan state.
// Depends on gbf_pkg only; instantiated by the testbench top beside the block.
module gbf_box_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  gbf_pkg::item_t            item,
  input  logic                      done,
  input  gbf_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gbf_pkg::CFG_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        pending_boxes
);

  localparam int SHEET_SPAN = 256;

  logic [31:0]               sheet_copy [0:SHEET_SPAN*SHEET_SPAN-1];
  logic [gbf_pkg::CFG_W-1:0] width_reg;
  logic [gbf_pkg::CFG_W-1:0] height_reg;
  logic [8:0]                cur_x;
  logic [8:0]                cur_y;
  logic [8:0]                row_h;
  logic                      scan_over;
  gbf_pkg::result_t          expected_boxes [$];
  gbf_pkg::result_t          want;

  initial begin
    mismatches = 0;
    pending_boxes = 0;
    for (int i = 0; i < SHEET_SPAN*SHEET_SPAN; i++) begin
      sheet_copy[i] = '0;
    end
  end

  // A size of zero counts as one; anything above the maximum counts as the maximum.
  function automatic int dim_in_use(logic [gbf_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    return (v > SHEET_SPAN) ? SHEET_SPAN : int'(v);
  endfunction

  function automatic logic [31:0] pixel_at(int x, int y);
    if (x >= SHEET_SPAN || y >= SHEET_SPAN) return '0;
    return sheet_copy[y*SHEET_SPAN + x];
  endfunction

  // Walks the sheet from the cursor to the next box, exactly as the block should.
  task automatic find_next_box(output gbf_pkg::result_t box);
    int          w;
    int          h;
    int          bw;
    int          bh;
    logic [31:0] key;
    logic [31:0] first;
    box = '0;
    w = dim_in_use(width_reg);
    h = dim_in_use(height_reg);
    if (scan_over) return;
    key = pixel_at(0, 0);
    forever begin
      if (cur_x >= w) begin
        cur_x = '0;
        cur_y = cur_y + row_h;
        row_h = 9'd1;
      end
      if (cur_y >= h) begin
        scan_over = 1'b1;
        return;
      end
      if (pixel_at(cur_x, cur_y) != key) break;
      cur_x = cur_x + 9'd1;
    end
    first = pixel_at(cur_x, cur_y);
    bw = 0;
    while (cur_x + bw < w && pixel_at(cur_x + bw, cur_y) != key) bw++;
    bh = 0;
    while (cur_y + bh < h && pixel_at(cur_x, cur_y + bh) != key) bh++;
    box.found = 1'b1;
    if (first != gbf_pkg::RED_MARKER) begin
      box.box_x  = cur_x[7:0];
      box.box_y  = cur_y[7:0];
      box.box_w  = 9'(bw);
      box.box_h  = 9'(bh);
      box.usable = 1'b1;
    end
    cur_x = cur_x + 9'(bw);
    row_h = 9'(bh);
  endtask

  task automatic report(string why, gbf_pkg::result_t exp_box);
    if (mismatches < 10) begin
      $display("%0t: %s: expected found=%0b x=%0d y=%0d w=%0d h=%0d usable=%0b, ",
               $realtime, why, exp_box.found, exp_box.box_x, exp_box.box_y,
               exp_box.box_w, exp_box.box_h, exp_box.usable,
               "got found=%0b x=%0d y=%0d w=%0d h=%0d usable=%0b",
               result.found, result.box_x, result.box_y,
               result.box_w, result.box_h, result.usable);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = gbf_pkg::SHEET_DIM_RESET;
      height_reg = gbf_pkg::SHEET_DIM_RESET;
      cur_x      = '0;
      cur_y      = '0;
      row_h      = 9'd1;
      scan_over  = 1'b0;
      expected_boxes.delete();
    end else begin
      if (done) begin
        if (expected_boxes.size() == 0) begin
          report("result word with nothing expected", '0);
        end else begin
          want = expected_boxes.pop_front();
          if (result !== want) report("box mismatch", want);
        end
      end
      if (cfg_we) begin
        if (cfg_index == gbf_pkg::REG_SHEET_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (start && !busy) begin
        case (item.command)
          gbf_pkg::CMD_WRITE: begin
            sheet_copy[{item.pixel_y, item.pixel_x}] = item.pixel_color;
          end
          gbf_pkg::CMD_RESTART: begin
            cur_x     = '0;
            cur_y     = '0;
            row_h     = 9'd1;
            scan_over = 1'b0;
          end
          gbf_pkg::CMD_FIND: begin
            find_next_box(want);
            expected_boxes.insert(expected_boxes.size(), want);
          end
          default: ;
        endcase
      end
    end
    pending_boxes = expected_boxes.size();
  end

endmodule

// File: tb/tb_sprite_sheet_glyph_box_finder.sv
`timescale 1ns / 100ps
// Testbench top for the glyph box finder: clock, reset, command words and the verdict.
// Depends on gbf_pkg, the block itself and gbf_box_checker.
module tb_sprite_sheet_glyph_box_finder;

  // The command code that the block must ignore has no name in the package.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SHEET_SPAN  = 256;
  localparam int WORD_TARGET = 1700;
  // Cycles with no word moving in either direction before the run is abandoned.
  localparam int QUIET_LIMIT = 20000;

  logic                      clk;
  logic                      rst;
  logic                      start;
  gbf_pkg::item_t            cmd_word;
  logic                      busy;
  logic                      done;
  gbf_pkg::result_t          box_word;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [gbf_pkg::CFG_W-1:0] cfg_data;
  int                        mismatches;
  int                        pending_boxes;
  int                        words_sent;
  int                        quiet_cycles;
  logic [31:0]               sheet_image [0:SHEET_SPAN*SHEET_SPAN-1];

  sprite_sheet_glyph_box_finder dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (cmd_word),
    .busy      (busy),
    .done      (done),
    .result    (box_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gbf_box_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (cmd_word),
    .done          (done),
    .result        (box_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_boxes (pending_boxes)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: any accepted command word or any result word counts as progress.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic gbf_pkg::item_t make_word(logic [1:0] cmd, logic [7:0] x,
                                               logic [7:0] y, logic [31:0] color);
    gbf_pkg::item_t w;
    w.command     = cmd;
    w.pixel_x     = x;
    w.pixel_y     = y;
    w.pixel_color = color;
    return w;
  endfunction

  // Offers one command word after a random gap and holds it until the block takes it.
  // When the gap is zero, start stays high from the previous word, so it is never
  // lowered and raised in the same time step.
  task automatic send_word(gbf_pkg::item_t w);
    int gap;
    gap = $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    cmd_word <= w;
    // Busy is sampled just after the rising edge, before the block updates it.
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // Stops offering words and waits until every expected box has come back, then
  // waits on so that any write or restart has settled too.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_boxes != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [gbf_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Writes both size registers; only ever called with the block idle.
  task automatic set_sheet(logic [gbf_pkg::CFG_W-1:0] wv, logic [gbf_pkg::CFG_W-1:0] hv);
    write_reg(gbf_pkg::REG_SHEET_WIDTH, wv);
    write_reg(gbf_pkg::REG_SHEET_HEIGHT, hv);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Paints a key background with a handful of rectangles over it, some of them
  // carrying the red marker, and then writes every pixel of the sheet in use so
  // that no find can ever read an unwritten pixel.
  task automatic paint_sheet(int w, int h);
    logic [31:0] key;
    logic [31:0] color;
    int          x0;
    int          y0;
    int          rw;
    int          rh;
    int          rects;
    key = $urandom();
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) sheet_image[y*SHEET_SPAN + x] = key;
    end
    rects = $urandom_range(0, 6);
    for (int r = 0; r < rects; r++) begin
      x0 = $urandom_range(0, w - 1);
      y0 = $urandom_range(0, h - 1);
      rw = $urandom_range(1, (w - x0 > 6) ? 6 : w - x0);
      rh = $urandom_range(1, (h - y0 > 6) ? 6 : h - y0);
      color = ($urandom_range(0, 3) == 0) ? gbf_pkg::RED_MARKER : $urandom();
      for (int y = y0; y < y0 + rh; y++) begin
        for (int x = x0; x < x0 + rw; x++) sheet_image[y*SHEET_SPAN + x] = color;
      end
    end
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        send_word(make_word(gbf_pkg::CMD_WRITE, 8'(x), 8'(y),
                            sheet_image[y*SHEET_SPAN + x]));
        // Now and then a stray write lands anywhere in the store.
        if ($urandom_range(0, 11) == 0) begin
          send_word(make_word(gbf_pkg::CMD_WRITE, 8'($urandom()), 8'($urandom()),
                              $urandom()));
        end
      end
    end
  endtask

  // A run of finds mixed with restarts, ignored commands and overwrites.
  task automatic scan_phase(int w, int h);
    int          ops;
    int          pick;
    logic [31:0] color;
    ops = $urandom_range(30, 70);
    for (int n = 0; n < ops; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_word(make_word(gbf_pkg::CMD_FIND, 8'($urandom()), 8'($urandom()),
                            $urandom()));
      end else if (pick < 70) begin
        send_word(make_word(gbf_pkg::CMD_RESTART, 8'($urandom()), 8'($urandom()),
                            $urandom()));
      end else if (pick < 75) begin
        send_word(make_word(CMD_UNUSED, 8'($urandom()), 8'($urandom()), $urandom()));
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0:       color = sheet_image[0];
          1:       color = gbf_pkg::RED_MARKER;
          default: color = $urandom();
        endcase
        send_word(make_word(gbf_pkg::CMD_WRITE, 8'($urandom_range(0, w - 1)),
                            8'($urandom_range(0, h - 1)), color));
      end else begin
        send_word(make_word(gbf_pkg::CMD_WRITE, 8'($urandom()), 8'($urandom()),
                            $urandom()));
      end
      // Occasionally hold off until every box in flight has come back.
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    int                        phase;
    int                        w;
    int                        h;
    logic [gbf_pkg::CFG_W-1:0] wv;
    logic [gbf_pkg::CFG_W-1:0] hv;
    rst        = 1'b1;
    start      = 1'b0;
    cmd_word   = '0;
    cfg_we     = 1'b0;
    cfg_index  = gbf_pkg::REG_SHEET_WIDTH;
    cfg_data   = '0;
    words_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    // Directed part on a three by two sheet. The box at (1,0) starts with the red
    // marker, so it comes back unusable; the next find wraps below the row height
    // and hits the end of the sheet, and a further find reports the end again.
    set_sheet(9'd3, 9'd2);
    send_word(make_word(gbf_pkg::CMD_WRITE, 8'd0, 8'd0, 32'h11223344));
    send_word(make_word(gbf_pkg::CMD_WRITE, 8'd1, 8'd0, gbf_pkg::RED_MARKER));
    send_word(make_word(gbf_pkg::CMD_WRITE, 8'd2, 8'd0, 32'h11223344));
    send_word(make_word(gbf_pkg::CMD_WRITE, 8'd0, 8'd1, 32'hFFFFFFFF));
    send_word(make_word(gbf_pkg::CMD_WRITE, 8'd1, 8'd1, 32'hFFFFFFFF));
    send_word(make_word(gbf_pkg::CMD_WRITE, 8'd2, 8'd1, 32'h11223344));
    send_word(make_word(gbf_pkg::CMD_FIND, 8'd0, 8'd0, 32'h0));
    send_word(make_word(gbf_pkg::CMD_FIND, 8'd0, 8'd0, 32'h0));
    send_word(make_word(gbf_pkg::CMD_FIND, 8'd0, 8'd0, 32'h0));
    // A restart brings the same unusable box back; the unused code does nothing.
    send_word(make_word(gbf_pkg::CMD_RESTART, 8'hFF, 8'hFF, 32'hFFFFFFFF));
    send_word(make_word(gbf_pkg::CMD_FIND, 8'hFF, 8'hFF, 32'hFFFFFFFF));
    send_word(make_word(CMD_UNUSED, 8'hFF, 8'hFF, 32'hFFFFFFFF));
    // A box that runs to the end of the row, then a wrap straight off the sheet.
    send_word(make_word(gbf_pkg::CMD_WRITE, 8'd2, 8'd0, 32'h00000000));
    send_word(make_word(gbf_pkg::CMD_RESTART, 8'd0, 8'd0, 32'h0));
    send_word(make_word(gbf_pkg::CMD_FIND, 8'd0, 8'd0, 32'h0));
    send_word(make_word(gbf_pkg::CMD_FIND, 8'd0, 8'd0, 32'h0));
    // A stray write at the far corner, then a usable two by two box.
    send_word(make_word(gbf_pkg::CMD_WRITE, 8'hFF, 8'hFF, 32'hFFFFFFFF));
    send_word(make_word(gbf_pkg::CMD_WRITE, 8'd1, 8'd0, 32'hFFFFFFFF));
    send_word(make_word(gbf_pkg::CMD_RESTART, 8'd0, 8'd0, 32'h0));
    send_word(make_word(gbf_pkg::CMD_FIND, 8'd0, 8'd0, 32'h0));
    send_word(make_word(gbf_pkg::CMD_FIND, 8'd0, 8'd0, 32'h0));
    drain();

    // Random phases. Most sheets are small; a few use the register extremes,
    // where zero counts as one and anything past the maximum as the maximum.
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      case (phase)
        2:       begin wv = 9'd511; hv = 9'd0;   end
        5:       begin wv = 9'd0;   hv = 9'd256; end
        8:       begin wv = 9'd1;   hv = 9'd511; end
        default: begin
          wv = 9'($urandom_range(1, 12));
          hv = 9'($urandom_range(1, 12));
        end
      endcase
      w = (wv == 0) ? 1 : ((wv > SHEET_SPAN) ? SHEET_SPAN : int'(wv));
      h = (hv == 0) ? 1 : ((hv > SHEET_SPAN) ? SHEET_SPAN : int'(hv));
      set_sheet(wv, hv);
      paint_sheet(w, h);
      // Start each scan from the origin so that the new sheet is walked whole.
      send_word(make_word(gbf_pkg::CMD_RESTART, 8'($urandom()), 8'($urandom()),
                          $urandom()));
      scan_phase(w, h);
      drain();
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_boxes == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/gbf_pkg.sv
hdl/gbf_seq.sv
hdl/gbf_dp.sv
hdl/sprite_sheet_glyph_box_finder.sv
tb/gbf_box_checker.sv
tb/tb_sprite_sheet_glyph_box_finder.sv
